// File: src/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg: shared types and constants for the positional PID core
// Sample and gain formats, register indexes and the structs that pass
// configuration, input words and results between the modules.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // Sample and gain formats
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 31;
  localparam int DRIVE_W        = 32;
  localparam int CFG_DATA_W     = 31;
  localparam int CFG_ADDR_W     = 3;

  // Derived datapath widths
  localparam int ERR_W   = SAMPLE_WIDTH + 1;          // error, target change
  localparam int DERR_W  = SAMPLE_WIDTH + 2;          // error change
  localparam int PE_W    = GAIN_W + ERR_W;            // gain * error
  localparam int PD_W    = GAIN_W + DERR_W;           // gain * error change
  localparam int INTEG_W = 48;                        // integral state
  localparam int SLIM_W  = LIMIT_W + GAIN_FRAC_BITS + 1;  // signed scaled limit
  localparam int ISUM_W  = ((INTEG_W > PE_W) ? INTEG_W : PE_W) + 1;
  localparam int SUM_W   = ((INTEG_W > PD_W) ? INTEG_W : PD_W) + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_GAIN_FF        = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [GAIN_W-1:0] gain_ff;
    logic [LIMIT_W-1:0]       output_limit;
    logic [LIMIT_W-1:0]       integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic                           clear;
  } item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      integral_clamped;
    logic                      output_saturated;
  } result_t;

endpackage

// File: src/positional_pid_with_feedforward_core.sv
// ----------------------------------------------------------------------------
// positional_pid_with_feedforward_core: positional PID with set-point
// feedforward, fixed point
// Input register, one pass of PID arithmetic, result register.
//
//   channel  direction  handshake             payload
//   in_      into core  in_valid / in_stall   target, measured, clear
//   out_     from core  out_valid / out_stall drive, integral_clamped,
//                                             output_saturated
//   cfg_     into core  cfg_we                cfg_addr, cfg_wdata
//
// One word per cycle while the output is not stalled; each word passes the input register, then the result register.
// The rate is set by the integral feedback loop, which closes through the
// arithmetic pass into the state registers.
// Synchronous active-low reset clears valids, history, integral and
// registers (limits to all ones). A stalled result holds its word; the input
// register takes one more word, then stalls until the result leaves.
// ----------------------------------------------------------------------------
module positional_pid_with_feedforward_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ppid_pkg::SAMPLE_WIDTH-1:0] in_target,
  input  logic signed [ppid_pkg::SAMPLE_WIDTH-1:0] in_measured,
  input  logic                                in_clear,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ppid_pkg::DRIVE_W-1:0] out_drive,
  output logic                                out_integral_clamped,
  output logic                                out_output_saturated,
  input  logic                                cfg_we,
  input  logic [ppid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ppid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ppid_pkg::*;

  cfg_t    cfg;
  item_t   in_item, s1_item;
  result_t result, out_result;
  logic    s1_valid, advance;

  assign in_item.target   = in_target;
  assign in_item.measured = in_measured;
  assign in_item.clear    = in_clear;

  ppid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppid_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ppid_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .s1_item (s1_item),
    .cfg     (cfg),
    .result  (result)
  );

  ppid_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_drive            = out_result.drive;
  assign out_integral_clamped = out_result.integral_clamped;
  assign out_output_saturated = out_result.output_saturated;

  // An empty result register never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // A result appears only after a word moved out of the input register
  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(advance) && $past(s1_valid))
    else $error("result valid without a word advancing");

  // A clear word yields a zero result with both flags low
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item.clear) |=>
      (out_drive == '0) && !out_integral_clamped && !out_output_saturated)
    else $error("clear word gave a nonzero result");

endmodule

// File: src/ppid_cfg.sv
// ----------------------------------------------------------------------------
// ppid_cfg: configuration register file
// Decodes the write port into the gain and limit registers.
// ----------------------------------------------------------------------------
module ppid_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppid_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ppid_pkg::cfg_t                  cfg
);
  import ppid_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:         cfg_nxt.gain_p         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_FF:        cfg_nxt.gain_ff        = cfg_wdata[GAIN_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_nxt.output_limit   = cfg_wdata[LIMIT_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_wdata[LIMIT_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.gain_ff        <= '0;
      cfg_r.output_limit   <= LIMIT_RESET;
      cfg_r.integral_limit <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/ppid_in_stage.sv
// ----------------------------------------------------------------------------
// ppid_in_stage: input register
// Captures one word per cycle unless stalled and holds it until the result stage takes it.
// ----------------------------------------------------------------------------
module ppid_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ppid_pkg::item_t in_item,
  input  logic            advance,
  output logic            s1_valid,
  output ppid_pkg::item_t s1_item
);
  import ppid_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Stall only while a held word cannot move on this cycle
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: src/ppid_calc.sv
// ----------------------------------------------------------------------------
// ppid_calc: PID arithmetic and controller state
// Error, changes, four products, integral clamp and output clamp in one
// pass; the history and integral registers update when a word moves on.
// ----------------------------------------------------------------------------
module ppid_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  ppid_pkg::item_t   s1_item,
  input  ppid_pkg::cfg_t    cfg,
  output ppid_pkg::result_t result
);
  import ppid_pkg::*;

  logic signed [ERR_W-1:0]        prev_err_r, prev_err_nxt;
  logic signed [SAMPLE_WIDTH-1:0] prev_tgt_r, prev_tgt_nxt;
  logic signed [INTEG_W-1:0]      integ_r, integ_nxt;

  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic signed [ERR_W-1:0]  dtgt;
  logic signed [PE_W-1:0]   prod_p, prod_i, prod_f;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [SLIM_W-1:0] ilim, olim;
  logic signed [ISUM_W-1:0] isum_raw, isum_cl, ilim_pos, ilim_neg;
  logic signed [SUM_W-1:0]  sum_raw, sum_cl, olim_pos, olim_neg;
  logic                     ihit, ohit;

  // Error and changes, widened by one bit so nothing wraps
  assign err  = ERR_W'(s1_item.target) - ERR_W'(s1_item.measured);
  assign derr = DERR_W'(err) - DERR_W'(prev_err_r);
  assign dtgt = ERR_W'(s1_item.target) - ERR_W'(prev_tgt_r);

  // Gain products, exact, GAIN_FRAC_BITS fraction bits
  assign prod_p = PE_W'(cfg.gain_p) * PE_W'(err);
  assign prod_i = PE_W'(cfg.gain_i) * PE_W'(err);
  assign prod_f = PE_W'(cfg.gain_ff) * PE_W'(dtgt);
  assign prod_d = PD_W'(cfg.gain_d) * PD_W'(derr);

  // Limits scaled to the fraction format
  assign ilim = {1'b0, cfg.integral_limit, {GAIN_FRAC_BITS{1'b0}}};
  assign olim = {1'b0, cfg.output_limit, {GAIN_FRAC_BITS{1'b0}}};

  // Integral accumulate and symmetric clamp
  assign isum_raw = ISUM_W'(integ_r) + ISUM_W'(prod_i);
  assign ilim_pos = ISUM_W'(ilim);
  assign ilim_neg = -ilim_pos;

  always_comb begin
    ihit    = 1'b1;
    isum_cl = isum_raw;
    if (isum_raw > ilim_pos) begin
      isum_cl = ilim_pos;
    end else if (isum_raw < ilim_neg) begin
      isum_cl = ilim_neg;
    end else begin
      ihit = 1'b0;
    end
  end

  // Output sum and symmetric clamp
  assign sum_raw = SUM_W'(prod_p) + SUM_W'(isum_cl) + SUM_W'(prod_d) + SUM_W'(prod_f);
  assign olim_pos = SUM_W'(olim);
  assign olim_neg = -olim_pos;

  always_comb begin
    ohit   = 1'b1;
    sum_cl = sum_raw;
    if (sum_raw > olim_pos) begin
      sum_cl = olim_pos;
    end else if (sum_raw < olim_neg) begin
      sum_cl = olim_neg;
    end else begin
      ohit = 1'b0;
    end
  end

  // Result: drop fraction bits (floor); a clear word gives all zeros
  always_comb begin
    if (s1_item.clear) begin
      result = '0;
    end else begin
      result.drive            = sum_cl[GAIN_FRAC_BITS +: DRIVE_W];
      result.integral_clamped = ihit;
      result.output_saturated = ohit;
    end
  end

  // State update; clear keeps the previous target
  always_comb begin
    prev_err_nxt = prev_err_r;
    prev_tgt_nxt = prev_tgt_r;
    integ_nxt    = integ_r;
    if (advance) begin
      if (s1_item.clear) begin
        prev_err_nxt = '0;
        integ_nxt    = '0;
      end else begin
        prev_err_nxt = err;
        prev_tgt_nxt = s1_item.target;
        integ_nxt    = INTEG_W'(isum_cl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      prev_tgt_r <= '0;
      integ_r    <= '0;
    end else begin
      prev_err_r <= prev_err_nxt;
      prev_tgt_r <= prev_tgt_nxt;
      integ_r    <= integ_nxt;
    end
  end

endmodule

// File: src/ppid_out_stage.sv
// ----------------------------------------------------------------------------
// ppid_out_stage: result register
// Holds one result word; takes a new one whenever it is empty or drained.
// ----------------------------------------------------------------------------
module ppid_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  ppid_pkg::result_t result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output ppid_pkg::result_t out_result
);
  import ppid_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  // Move on when the register is empty or its word leaves this cycle
  assign advance = s1_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule
